// ===== rtl/average_true_range_top_defines.svh =====
// assertion macros for the average true range block
// used by the checker file; no other dependencies
`ifndef AVERAGE_TRUE_RANGE_TOP_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ATR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ATR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/atr_pkg.sv =====
// shared widths, register indexes and control structs for the atr block
// no dependencies
package atr_pkg;

   localparam int PRICE_W    = 32;
   localparam int PERIOD_W   = 8;
   localparam int SKIP_W     = 16;
   localparam int SUM_W      = 40;
   localparam int COUNT_W    = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int DIV_STEPS  = SUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP   = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
   localparam logic [SKIP_W-1:0]   SKIP_RESET   = 16'd0;

   typedef struct packed {
      logic capture;
      logic range;
      logic accum;
      logic take_quot;
      logic emit;
   } atr_cmd_type;

   typedef struct packed {
      logic restart;
      logic have_last;
      logic seeding;
      logic last_seed;
      logic emit_pending;
      logic out_free;
      logic div_busy;
   } atr_sts_type;

endpackage

// ===== rtl/atr_req_if.sv =====
// bar input channel: valid, ready and one price bar
// depends on atr_pkg
interface atr_req_if
   import atr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] bar_high;
   logic [PRICE_W-1:0] bar_low;
   logic [PRICE_W-1:0] bar_close;

   modport source (output valid, bar_high, bar_low, bar_close, input ready);
   modport sink (input valid, bar_high, bar_low, bar_close, output ready);
endinterface

// ===== rtl/atr_rsp_if.sv =====
// result channel: valid, ready, average and bar index
// depends on atr_pkg
interface atr_rsp_if
   import atr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [PRICE_W-1:0] atr_value;
   logic [COUNT_W-1:0] bar_number;

   modport source (output valid, atr_value, bar_number, input ready);
   modport sink (input valid, atr_value, bar_number, output ready);
endinterface

// ===== rtl/atr_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on atr_pkg
module atr_div
   import atr_pkg::*;
   (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_W-1:0]    dividend,
   input  logic [PERIOD_W-1:0] divisor,
   output logic                busy,
   output logic [SUM_W-1:0]    quotient
);

   logic [SUM_W-1:0]    quo_ff, quo_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [PERIOD_W:0]   shifted;
   logic [PERIOD_W:0]   diff;
   logic                ge;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign diff    = shifted - {1'b0, divisor};
   assign ge      = (shifted >= {1'b0, divisor});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/atr_ctrl.sv =====
// sequencer for one bar: capture, range, accumulate, divide, emit
// depends on atr_pkg
module atr_ctrl
   import atr_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  atr_sts_type sts,
   output atr_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RANGE  = 3'd1;
   localparam logic [2:0] ST_ACCUM  = 3'd2;
   localparam logic [2:0] ST_DIVIDE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_RANGE;
            end
         end
         ST_RANGE: begin
            cmd.range = 1'b1;
            state_in  = sts.have_last ? ST_ACCUM : ST_IDLE;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = (sts.seeding && !sts.last_seed) ? ST_IDLE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!sts.div_busy) begin
               cmd.take_quot = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!sts.emit_pending) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (sts.restart) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/atr_dp.sv =====
// datapath: config, true range, seed sum, wilder step, output register
// depends on atr_pkg and atr_div
module atr_dp
   import atr_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   input  atr_cmd_type           cmd,
   output atr_sts_type           sts,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [PRICE_W-1:0]    req_bar_high,
   input  logic [PRICE_W-1:0]    req_bar_low,
   input  logic [PRICE_W-1:0]    req_bar_close,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PRICE_W-1:0]    rsp_atr_value,
   output logic [COUNT_W-1:0]    rsp_bar_number
);

   logic [PERIOD_W-1:0] period_ff;
   logic [SKIP_W-1:0]   skip_cfg_ff;
   logic [PRICE_W-1:0]  hi_ff, lo_ff, cl_ff;
   logic [PRICE_W-1:0]  last_close_ff;
   logic                have_last_ff;
   logic [PERIOD_W-1:0] seed_count_ff;
   logic [SUM_W-1:0]    seed_sum_ff;
   logic [SKIP_W-1:0]   skip_left_ff;
   logic [PRICE_W-1:0]  avg_ff;
   logic [COUNT_W-1:0]  bar_counter_ff;
   logic [COUNT_W-1:0]  index_ff;
   logic [PRICE_W-1:0]  tr_ff;
   logic [SUM_W-1:0]    prod_ff;
   logic                emit_ff;
   logic                out_valid_ff;
   logic [PRICE_W-1:0]  out_value_ff;
   logic [COUNT_W-1:0]  out_number_ff;

   logic [PERIOD_W-1:0] p_eff;
   logic [PERIOD_W-1:0] p_less1;
   logic [SKIP_W-1:0]   skip_reload;
   logic [PRICE_W-1:0]  d_hl, d_ch, d_cl, tr_max;
   logic [SUM_W-1:0]    prod;
   logic [SUM_W-1:0]    sum_next;
   logic [SUM_W-1:0]    smooth_next;
   logic [SKIP_W-1:0]   skip_dec;
   logic                seeding, last_seed, out_free;
   logic                div_start, div_busy;
   logic [SUM_W-1:0]    div_dividend, quotient;

   // period zero acts as period one
   assign p_eff   = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign p_less1 = p_eff - 1'b1;

   assign skip_reload = (csr_index == CSR_SKIP) ? csr_wdata[SKIP_W-1:0] : skip_cfg_ff;

   // high below low never wins against the close distances
   assign d_hl   = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : '0;
   assign d_ch   = (last_close_ff >= hi_ff) ? (last_close_ff - hi_ff) : (hi_ff - last_close_ff);
   assign d_cl   = (last_close_ff >= lo_ff) ? (last_close_ff - lo_ff) : (lo_ff - last_close_ff);
   assign tr_max = (d_ch > d_hl) ? ((d_cl > d_ch) ? d_cl : d_ch)
                                 : ((d_cl > d_hl) ? d_cl : d_hl);

   assign prod        = SUM_W'(avg_ff) * SUM_W'(p_less1);
   assign sum_next    = seed_sum_ff + SUM_W'(tr_ff);
   assign smooth_next = prod_ff + SUM_W'(tr_ff);
   assign skip_dec    = (skip_left_ff == '0) ? '0 : (skip_left_ff - 1'b1);

   assign seeding   = (seed_count_ff < p_eff);
   assign last_seed = (({1'b0, seed_count_ff} + 1'b1) == {1'b0, p_eff});
   assign out_free  = !out_valid_ff || rsp_ready;

   assign div_start    = cmd.accum && !(seeding && !last_seed);
   assign div_dividend = seeding ? sum_next : smooth_next;

   atr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (p_eff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      sts              = '0;
      sts.restart      = csr_we;
      sts.have_last    = have_last_ff;
      sts.seeding      = seeding;
      sts.last_seed    = last_seed;
      sts.emit_pending = emit_ff;
      sts.out_free     = out_free;
      sts.div_busy     = div_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= PERIOD_RESET;
         skip_cfg_ff    <= SKIP_RESET;
         have_last_ff   <= 1'b0;
         last_close_ff  <= '0;
         seed_count_ff  <= '0;
         seed_sum_ff    <= '0;
         skip_left_ff   <= SKIP_RESET;
         avg_ff         <= '0;
         bar_counter_ff <= '0;
         emit_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_PERIOD) begin
               period_ff <= csr_wdata[PERIOD_W-1:0];
            end else begin
               skip_cfg_ff <= csr_wdata[SKIP_W-1:0];
            end
            have_last_ff   <= 1'b0;
            last_close_ff  <= '0;
            seed_count_ff  <= '0;
            seed_sum_ff    <= '0;
            skip_left_ff   <= skip_reload;
            avg_ff         <= '0;
            bar_counter_ff <= '0;
            emit_ff        <= 1'b0;
         end else begin
            if (cmd.capture) begin
               if (bar_counter_ff != '1) begin
                  bar_counter_ff <= bar_counter_ff + 1'b1;
               end
            end
            if (cmd.range) begin
               last_close_ff <= cl_ff;
               have_last_ff  <= 1'b1;
            end
            if (cmd.accum) begin
               if (seeding) begin
                  seed_sum_ff   <= sum_next;
                  seed_count_ff <= seed_count_ff + 1'b1;
                  emit_ff       <= (skip_left_ff == '0);
               end else begin
                  skip_left_ff <= skip_dec;
                  emit_ff      <= (skip_dec == '0);
               end
            end
            if (cmd.take_quot) begin
               avg_ff <= quotient[PRICE_W-1:0];
            end
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hi_ff    <= req_bar_high;
         lo_ff    <= req_bar_low;
         cl_ff    <= req_bar_close;
         index_ff <= bar_counter_ff;
      end
      if (cmd.range) begin
         tr_ff   <= tr_max;
         prod_ff <= prod;
      end
      if (cmd.emit) begin
         out_value_ff  <= avg_ff;
         out_number_ff <= index_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_atr_value  = out_value_ff;
   assign rsp_bar_number = out_number_ff;

endmodule

// ===== rtl/average_true_range_top.sv =====
// top level of the wilder average true range block
// depends on atr_pkg, atr_req_if, atr_rsp_if, atr_ctrl, atr_dp, atr_div
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------
//   req_ch  | in  | valid / ready      | bar_high, bar_low, bar_close (q16.16)
//   rsp_ch  | out | valid / ready      | atr_value (q16.16), bar_number
//   csr     | in  | csr_we, no wait    | csr_index, csr_wdata
//
// one bar at a time: a bar that only stores its close passes capture and range, a seed
// bar that does not finish the seed also passes accumulate, and a bar that ends in a divide
// goes on through the radix-2 divider and emit, plus any wait for rsp space
// a finished result sits in the rsp register, so the next bar is taken while it waits
// reset is synchronous, active high; a csr write restarts the bar stream
module average_true_range_top
   import atr_pkg::*;
   (
   input  logic                  clock,
   input  logic                  reset,
   atr_req_if.sink               req_ch,
   atr_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // commands from the sequencer, status back from the datapath
   atr_cmd_type cmd;
   atr_sts_type sts;

   // sequencer: one state per step of a bar, ready only when idle
   atr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: range, seed sum, smoothing multiply, divider, output register
   atr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_bar_high   (req_ch.bar_high),
      .req_bar_low    (req_ch.bar_low),
      .req_bar_close  (req_ch.bar_close),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_atr_value  (rsp_ch.atr_value),
      .rsp_bar_number (rsp_ch.bar_number)
   );

endmodule

// ===== rtl/atr_checker.sv =====
// port-level checks for the average true range top, bound to it below
// depends on average_true_range_top_defines.svh
`include "average_true_range_top_defines.svh"

module atr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_we
);

   // a pending result is held until its transfer
   `ATR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped while stalled")

   // one bar at a time: no back-to-back transfer on req
   `ATR_ASSERT_NEXT(a_req_busy, req_valid && req_ready && !csr_we, !req_ready, "req ready right after a transfer")

   // a new result only comes out of a bar in flight
   `ATR_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "rsp appeared while idle")

endmodule

bind average_true_range_top atr_checker u_atr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .csr_we    (csr_we)
);
